// File: rtl/core/dbb_pkg.sv
// dbb_pkg: shared types, sizes and codes of the draw batch builder
// no dependencies; used by every module under rtl/core

package dbb_pkg;

    // texture slot table depth and derived widths
    localparam int MAX_TEXTURE_SLOTS = 8;
    localparam int FILL_W = $clog2(MAX_TEXTURE_SLOTS + 1);
    localparam int SLOT_W = (MAX_TEXTURE_SLOTS > 1) ? $clog2(MAX_TEXTURE_SLOTS) : 1;

    // fixed field widths
    localparam int PRIM_W     = 8;
    localparam int HANDLE_W   = 32;
    localparam int PAGE_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int CFG_TEX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int SLOT_OUT_W = 3;

    localparam logic [COUNT_W-1:0] FULL_RANGE = '1;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TEX_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INST_LIMIT = 1'b1;
    localparam logic [CFG_TEX_W-1:0] CFG_TEX_RESET = 4'd8;
    localparam logic [COUNT_W-1:0]   CFG_LIMIT_RESET = 32'd65536;

    typedef enum logic [2:0] {
        BRK_FIRST = 3'd0,
        BRK_STATE = 3'd1,
        BRK_PAGE  = 3'd2,
        BRK_INST  = 3'd3,
        BRK_TEX   = 3'd4
    } t_break_reason;

    typedef struct packed {
        logic                start_list;
        logic [PRIM_W-1:0]   primitive_kind;
        logic [HANDLE_W-1:0] material_handle;
        logic [HANDLE_W-1:0] clip_handle;
        logic [PAGE_W-1:0]   storage_page_id;
        logic [HANDLE_W-1:0] texture_handle;
        logic [HANDLE_W-1:0] instance_ref;
    } t_item;

    typedef struct packed {
        logic [HANDLE_W-1:0]   instance_out;
        logic [SLOT_OUT_W-1:0] texture_slot;
        logic [COUNT_W-1:0]    instance_position;
        logic [COUNT_W-1:0]    batch_index;
        logic                  opened_batch;
        t_break_reason         break_reason;
        logic                  overflow_error;
    } t_result;

    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   idx;
        logic [HANDLE_W-1:0] data;
    } t_slot_wr;

    typedef struct packed {
        logic              found;
        logic [FILL_W-1:0] idx;
    } t_slot_match;

endpackage

// File: rtl/core/dbb_slot_table.sv
// dbb_slot_table: texture slot registers of the open batch with parallel lookup
// depends on dbb_pkg

module dbb_slot_table (
    input  logic                         i_clk,
    input  dbb_pkg::t_slot_wr            i_wr,
    input  logic [dbb_pkg::HANDLE_W-1:0] i_texture,
    input  logic [dbb_pkg::FILL_W-1:0]   i_filled,
    output dbb_pkg::t_slot_match         o_match
);

    logic [dbb_pkg::HANDLE_W-1:0] r_slot [dbb_pkg::MAX_TEXTURE_SLOTS];
    logic [dbb_pkg::MAX_TEXTURE_SLOTS-1:0] w_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_slot[i_wr.idx] <= i_wr.data;
        end
    end

    // only slots below the fill count hold live textures
    always_comb begin
        for (int i = 0; i < dbb_pkg::MAX_TEXTURE_SLOTS; i++) begin
            w_hit[i] = (dbb_pkg::FILL_W'(i) < i_filled) && (r_slot[i] == i_texture);
        end
    end

    // lowest matching slot wins
    always_comb begin
        o_match.found = 1'b0;
        o_match.idx   = i_filled;
        for (int i = dbb_pkg::MAX_TEXTURE_SLOTS - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                o_match.found = 1'b1;
                o_match.idx   = dbb_pkg::FILL_W'(i);
            end
        end
    end

endmodule

// File: rtl/core/dbb_batch_ctrl.sv
// dbb_batch_ctrl: current batch state, join or break decision and counters
// depends on dbb_pkg and dbb_slot_table

module dbb_batch_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  dbb_pkg::t_item                i_item,
    input  logic [dbb_pkg::CFG_TEX_W-1:0] i_cfg_tex_slots,
    input  logic [dbb_pkg::COUNT_W-1:0]   i_cfg_inst_limit,
    output dbb_pkg::t_result              o_result
);

    logic                         r_open;
    logic [dbb_pkg::PRIM_W-1:0]   r_prim;
    logic [dbb_pkg::HANDLE_W-1:0] r_material;
    logic [dbb_pkg::HANDLE_W-1:0] r_clip;
    logic [dbb_pkg::PAGE_W-1:0]   r_page;
    logic [dbb_pkg::FILL_W-1:0]   r_filled;
    logic [dbb_pkg::COUNT_W-1:0]  r_batch_inst;
    logic [dbb_pkg::COUNT_W-1:0]  r_total_inst;
    logic [dbb_pkg::COUNT_W-1:0]  r_total_batches;

    logic                         n_open;
    logic [dbb_pkg::PRIM_W-1:0]   n_prim;
    logic [dbb_pkg::HANDLE_W-1:0] n_material;
    logic [dbb_pkg::HANDLE_W-1:0] n_clip;
    logic [dbb_pkg::PAGE_W-1:0]   n_page;
    logic [dbb_pkg::FILL_W-1:0]   n_filled;
    logic [dbb_pkg::COUNT_W-1:0]  n_batch_inst;
    logic [dbb_pkg::COUNT_W-1:0]  n_total_inst;
    logic [dbb_pkg::COUNT_W-1:0]  n_total_batches;

    logic                        w_open;
    logic [dbb_pkg::COUNT_W-1:0] w_total_inst;
    logic [dbb_pkg::COUNT_W-1:0] w_total_batches;
    logic                        w_overflow;
    logic [dbb_pkg::FILL_W-1:0]  w_tex_cap;
    logic [dbb_pkg::COUNT_W-1:0] w_inst_cap;
    logic [dbb_pkg::COUNT_W-1:0] w_slot32;
    dbb_pkg::t_break_reason      w_reason;
    logic                        w_join;
    dbb_pkg::t_slot_match        w_match;
    dbb_pkg::t_slot_wr           w_slot_wr;

    dbb_slot_table u_slot_table (
        .i_clk     (i_clk),
        .i_wr      (w_slot_wr),
        .i_texture (i_item.texture_handle),
        .i_filled  (r_filled),
        .o_match   (w_match)
    );

    // start of list clears the batch state ahead of this word
    assign w_open          = r_open && !i_item.start_list;
    assign w_total_inst    = i_item.start_list ? '0 : r_total_inst;
    assign w_total_batches = i_item.start_list ? '0 : r_total_batches;
    assign w_overflow      = (w_total_inst == dbb_pkg::FULL_RANGE);

    // clamp the limits to their usable ranges
    always_comb begin
        if (i_cfg_tex_slots == '0) begin
            w_tex_cap = dbb_pkg::FILL_W'(1);
        end else if (32'(i_cfg_tex_slots) > dbb_pkg::MAX_TEXTURE_SLOTS) begin
            w_tex_cap = dbb_pkg::FILL_W'(dbb_pkg::MAX_TEXTURE_SLOTS);
        end else begin
            w_tex_cap = dbb_pkg::FILL_W'(i_cfg_tex_slots);
        end
        w_inst_cap = (i_cfg_inst_limit == '0) ? dbb_pkg::COUNT_W'(1) : i_cfg_inst_limit;
    end

    always_comb begin
        w_join   = 1'b0;
        w_reason = dbb_pkg::BRK_FIRST;
        if (w_open) begin
            if (r_prim != i_item.primitive_kind || r_material != i_item.material_handle
                    || r_clip != i_item.clip_handle) begin
                w_reason = dbb_pkg::BRK_STATE;
            end else if (r_page != i_item.storage_page_id) begin
                w_reason = dbb_pkg::BRK_PAGE;
            end else if (r_batch_inst >= w_inst_cap) begin
                w_reason = dbb_pkg::BRK_INST;
            end else if (w_match.idx >= w_tex_cap) begin
                w_reason = dbb_pkg::BRK_TEX;
            end else begin
                w_join = 1'b1;
            end
        end
    end

    assign w_slot32 = dbb_pkg::COUNT_W'(w_match.idx);

    always_comb begin
        n_open          = w_open;
        n_prim          = r_prim;
        n_material      = r_material;
        n_clip          = r_clip;
        n_page          = r_page;
        n_filled        = i_item.start_list ? '0 : r_filled;
        n_batch_inst    = i_item.start_list ? '0 : r_batch_inst;
        n_total_inst    = w_total_inst;
        n_total_batches = w_total_batches;
        w_slot_wr.en    = 1'b0;
        w_slot_wr.idx   = '0;
        w_slot_wr.data  = i_item.texture_handle;

        o_result                   = '0;
        o_result.instance_out      = i_item.instance_ref;
        o_result.instance_position = w_total_inst;

        if (w_overflow) begin
            o_result                = '0;
            o_result.overflow_error = 1'b1;
        end else if (w_join) begin
            // a new texture takes the next free slot
            if (!w_match.found && (32'(w_match.idx) < dbb_pkg::MAX_TEXTURE_SLOTS)) begin
                w_slot_wr.en  = i_fire;
                w_slot_wr.idx = dbb_pkg::SLOT_W'(w_match.idx);
                n_filled      = w_match.idx + dbb_pkg::FILL_W'(1);
            end
            n_batch_inst          = r_batch_inst + dbb_pkg::COUNT_W'(1);
            n_total_inst          = w_total_inst + dbb_pkg::COUNT_W'(1);
            o_result.texture_slot = w_slot32[dbb_pkg::SLOT_OUT_W-1:0];
            o_result.batch_index  = w_total_batches - dbb_pkg::COUNT_W'(1);
        end else begin
            n_open                = 1'b1;
            n_prim                = i_item.primitive_kind;
            n_material            = i_item.material_handle;
            n_clip                = i_item.clip_handle;
            n_page                = i_item.storage_page_id;
            n_filled              = dbb_pkg::FILL_W'(1);
            n_batch_inst          = dbb_pkg::COUNT_W'(1);
            n_total_inst          = w_total_inst + dbb_pkg::COUNT_W'(1);
            n_total_batches       = w_total_batches + dbb_pkg::COUNT_W'(1);
            w_slot_wr.en          = i_fire;
            w_slot_wr.idx         = '0;
            o_result.batch_index  = w_total_batches;
            o_result.opened_batch = 1'b1;
            o_result.break_reason = w_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open          <= 1'b0;
            r_prim          <= '0;
            r_material      <= '0;
            r_clip          <= '0;
            r_page          <= '0;
            r_filled        <= '0;
            r_batch_inst    <= '0;
            r_total_inst    <= '0;
            r_total_batches <= '0;
        end else if (i_fire) begin
            r_open          <= n_open;
            r_prim          <= n_prim;
            r_material      <= n_material;
            r_clip          <= n_clip;
            r_page          <= n_page;
            r_filled        <= n_filled;
            r_batch_inst    <= n_batch_inst;
            r_total_inst    <= n_total_inst;
            r_total_batches <= n_total_batches;
        end
    end

    a_total_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_item.start_list && !w_overflow
        |=> r_total_inst == $past(r_total_inst) + dbb_pkg::COUNT_W'(1))
        else $error("instance total did not advance by one");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_filled) <= dbb_pkg::MAX_TEXTURE_SLOTS)
        else $error("slot fill count beyond table depth");

    a_open_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !w_overflow |=> r_open)
        else $error("placed word left no open batch");

endmodule

// File: rtl/core/draw_batch_builder.sv
// draw_batch_builder: top level with input register, config registers and result register
// depends on dbb_pkg and dbb_batch_ctrl

// Groups a stream of draw words into batches and returns one result word per
// input word. A word is taken every cycle while the output is not stalled:
// the join or break decision and the batch state update are made while it
// sits in the input register, and its result is loaded into the output
// register as the word leaves it. The one-word-per-cycle rate is set by the
// batch state loop, which compares each word against the open batch and all
// eight texture slots combinationally. The result register lets a new word
// enter while a finished result still waits.
// Configuration writes must be made while no word is in flight.

module draw_batch_builder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_start_list,
    input  logic [dbb_pkg::PRIM_W-1:0]     i_primitive_kind,
    input  logic [dbb_pkg::HANDLE_W-1:0]   i_material_handle,
    input  logic [dbb_pkg::HANDLE_W-1:0]   i_clip_handle,
    input  logic [dbb_pkg::PAGE_W-1:0]     i_storage_page_id,
    input  logic [dbb_pkg::HANDLE_W-1:0]   i_texture_handle,
    input  logic [dbb_pkg::HANDLE_W-1:0]   i_instance_ref,
    input  logic                           i_cfg_we,
    input  logic [dbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dbb_pkg::HANDLE_W-1:0]   o_instance_out,
    output logic [dbb_pkg::SLOT_OUT_W-1:0] o_texture_slot,
    output logic [dbb_pkg::COUNT_W-1:0]    o_instance_position,
    output logic [dbb_pkg::COUNT_W-1:0]    o_batch_index,
    output logic                           o_opened_batch,
    output logic [2:0]                     o_break_reason,
    output logic                           o_overflow_error
);

    logic                          r_in_valid;
    dbb_pkg::t_item                r_in_item;
    dbb_pkg::t_item                n_in_item;
    logic                          r_out_valid;
    dbb_pkg::t_result              r_out;
    dbb_pkg::t_result              w_result;
    logic [dbb_pkg::CFG_TEX_W-1:0] r_cfg_tex_slots;
    logic [dbb_pkg::COUNT_W-1:0]   r_cfg_inst_limit;
    logic                          w_advance;
    logic                          w_accept;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    assign n_in_item.start_list      = i_start_list;
    assign n_in_item.primitive_kind  = i_primitive_kind;
    assign n_in_item.material_handle = i_material_handle;
    assign n_in_item.clip_handle     = i_clip_handle;
    assign n_in_item.storage_page_id = i_storage_page_id;
    assign n_in_item.texture_handle  = i_texture_handle;
    assign n_in_item.instance_ref    = i_instance_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tex_slots  <= dbb_pkg::CFG_TEX_RESET;
            r_cfg_inst_limit <= dbb_pkg::CFG_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dbb_pkg::CFG_IDX_TEX_SLOTS: begin
                    r_cfg_tex_slots <= i_cfg_data[dbb_pkg::CFG_TEX_W-1:0];
                end
                dbb_pkg::CFG_IDX_INST_LIMIT: begin
                    r_cfg_inst_limit <= i_cfg_data[dbb_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= n_in_item;
        end
    end

    dbb_batch_ctrl u_batch_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_advance),
        .i_item           (r_in_item),
        .i_cfg_tex_slots  (r_cfg_tex_slots),
        .i_cfg_inst_limit (r_cfg_inst_limit),
        .o_result         (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_instance_out      = r_out.instance_out;
    assign o_texture_slot      = r_out.texture_slot;
    assign o_instance_position = r_out.instance_position;
    assign o_batch_index       = r_out.batch_index;
    assign o_opened_batch      = r_out.opened_batch;
    assign o_break_reason      = r_out.break_reason;
    assign o_overflow_error    = r_out.overflow_error;

    a_reason_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (o_break_reason != dbb_pkg::BRK_FIRST) |-> o_opened_batch)
        else $error("break reason given on a word that joined");

    a_overflow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_overflow_error
        |-> !o_opened_batch && (o_instance_position == '0) && (o_batch_index == '0))
        else $error("dropped word carries result fields");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed word did not reach the result register");

endmodule
